FILE: design/tttm_pkg.sv
// Shared types, constants and arithmetic helpers of the thermal trip threshold monitor.
package tttm_pkg;

  localparam int CODE_W     = 8;
  localparam int DEGC_IN_W  = 11;
  localparam int DEGC_OUT_W = 9;
  localparam int IDX_W      = 2;
  localparam int NUM_TRIPS  = 4;

  // Calibrated offset in millidegrees: 30000 - 702 * calibration code.
  localparam int OFFSET_W    = 20;
  localparam int SLOPE_MILLI = 702;
  localparam int CAL_MILLI   = 30000;
  localparam int PROD_W      = 18;

  // Signed millidegree width of a requested trip temperature after scaling.
  localparam int MILLI_W     = 22;

  // Reciprocal constants for exact division of narrow values by 1000 and 702.
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = 37;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 37'd268436;
  localparam logic [RECIP_W-1:0] RECIP_702  = 37'd382387;
  localparam int HALF_SCALE   = 500;
  localparam int HALF_SLOPE   = 351;
  localparam int CLAMP_LIMIT  = 256 * SLOPE_MILLI;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic CFG_IDX_CAL = 1'b0;

  // Trip slots.
  localparam logic [IDX_W-1:0] TRIP_UPPER = 2'd1;
  localparam logic [IDX_W-1:0] TRIP_LOWER = 2'd2;
  localparam logic [CODE_W-1:0] TRIP_RESET [NUM_TRIPS] = '{8'hFF, 8'hDF, 8'h50, 8'h38};
  localparam logic [CODE_W-1:0] CODE_MAX = 8'hFF;

  typedef enum logic [1:0] {
    REQ_SAMPLE     = 2'd0,
    REQ_SET_TRIP   = 2'd1,
    REQ_SET_ENABLE = 2'd2,
    REQ_READ_TRIP  = 2'd3
  } req_kind_t;

  // One accepted request as held in the input register.
  typedef struct packed {
    req_kind_t                    kind;
    logic [CODE_W-1:0]            sensor_code;
    logic [IDX_W-1:0]             trip_index;
    logic signed [DEGC_IN_W-1:0]  temp_degc;
    logic                         trip_enable;
  } req_t;

  // Operation presented to the trip bank.
  typedef struct packed {
    req_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [CODE_W-1:0] new_code;
    logic              enable;
    logic [CODE_W-1:0] sensor_code;
  } bank_op_t;

  // Status returned by the trip bank for the current operation.
  typedef struct packed {
    logic [CODE_W-1:0] sel_code;
    logic              order_error;
    logic              upper_hit;
    logic              lower_hit;
  } bank_sts_t;

  // code * 702 as shifts and adds: 702 = 512 + 128 + 64 - 2.
  function automatic logic [PROD_W-1:0] code_times_slope(input logic [CODE_W-1:0] code);
    logic [PROD_W-1:0] c;
    c = PROD_W'(code);
    return (c << 9) + (c << 7) + (c << 6) - (c << 1);
  endfunction

endpackage

FILE: design/tttm_if.sv
// Request and response channel interfaces of the thermal trip threshold monitor.
interface tttm_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             req_type;
  logic [tttm_pkg::CODE_W-1:0]            sensor_code;
  logic [tttm_pkg::IDX_W-1:0]             trip_index;
  logic signed [tttm_pkg::DEGC_IN_W-1:0]  temp_degc;
  logic                                   trip_enable;

  modport source (output valid, req_type, sensor_code, trip_index, temp_degc, trip_enable,
                  input ready);
  modport sink   (input valid, req_type, sensor_code, trip_index, temp_degc, trip_enable,
                  output ready);
endinterface

interface tttm_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tttm_pkg::DEGC_OUT_W-1:0] temp_out;
  logic                                   upper_hit;
  logic                                   lower_hit;
  logic                                   order_error;

  modport source (output valid, temp_out, upper_hit, lower_hit, order_error, input ready);
  modport sink   (input valid, temp_out, upper_hit, lower_hit, order_error, output ready);
endinterface

FILE: design/tttm_apb_regs.sv
// Configuration register file: calibration code and the derived conversion offset.
module tttm_apb_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tttm_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [tttm_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [tttm_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready,
  output logic signed [tttm_pkg::OFFSET_W-1:0]  cal_offset
);

  logic [tttm_pkg::CODE_W-1:0]  cal_code;
  logic                         wr_cal;
  logic [tttm_pkg::PROD_W-1:0]  wr_prod;
  logic signed [tttm_pkg::OFFSET_W-1:0] offset_next;

  assign pready = 1'b1;
  assign wr_cal = psel && penable && pwrite && (paddr[2] == tttm_pkg::CFG_IDX_CAL);

  // The offset is precomputed here so the request path sees a plain register.
  assign wr_prod     = tttm_pkg::code_times_slope(pwdata[tttm_pkg::CODE_W-1:0]);
  assign offset_next = tttm_pkg::OFFSET_W'(tttm_pkg::CAL_MILLI)
                       - $signed({2'b00, wr_prod});

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_code   <= '0;
      cal_offset <= tttm_pkg::OFFSET_W'(tttm_pkg::CAL_MILLI);
    end else if (wr_cal) begin
      cal_code   <= pwdata[tttm_pkg::CODE_W-1:0];
      cal_offset <= offset_next;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == tttm_pkg::CFG_IDX_CAL) begin
      prdata = tttm_pkg::APB_DATA_W'(cal_code);
    end
  end

endmodule

FILE: design/tttm_convert.sv
// Code to degrees and degrees to code conversion, combinational.
module tttm_convert (
  input  logic [tttm_pkg::CODE_W-1:0]            code_in,
  input  logic signed [tttm_pkg::DEGC_IN_W-1:0]  degc_in,
  input  logic signed [tttm_pkg::OFFSET_W-1:0]   cal_offset,
  output logic signed [tttm_pkg::DEGC_OUT_W-1:0] degc_out,
  output logic [tttm_pkg::CODE_W-1:0]            code_out
);

  // Code to degrees: v = code*702 + offset, v/1000 rounded half away from zero.
  logic [tttm_pkg::PROD_W-1:0]           prod;
  logic signed [tttm_pkg::OFFSET_W-1:0]  v;
  logic signed [tttm_pkg::OFFSET_W-1:0]  v_neg;
  logic [tttm_pkg::PROD_W-1:0]           mag;
  logic [tttm_pkg::PROD_W-1:0]           mag_rnd;
  logic [tttm_pkg::RECIP_W-1:0]          q_prod;
  logic [tttm_pkg::CODE_W-1:0]           q;
  logic [tttm_pkg::DEGC_OUT_W-1:0]       q_ext;

  assign prod    = tttm_pkg::code_times_slope(code_in);
  assign v       = $signed({2'b00, prod}) + cal_offset;
  assign v_neg   = -v;
  assign mag     = v[tttm_pkg::OFFSET_W-1] ? v_neg[tttm_pkg::PROD_W-1:0]
                                           : v[tttm_pkg::PROD_W-1:0];
  assign mag_rnd = mag + tttm_pkg::PROD_W'(tttm_pkg::HALF_SCALE);
  assign q_prod  = tttm_pkg::RECIP_W'(mag_rnd) * tttm_pkg::RECIP_1000;
  assign q       = q_prod[tttm_pkg::RECIP_SHIFT +: tttm_pkg::CODE_W];
  assign q_ext   = tttm_pkg::DEGC_OUT_W'(q);
  assign degc_out = v[tttm_pkg::OFFSET_W-1] ? $signed(-q_ext) : $signed(q_ext);

  // Degrees to code: n = degc*1000 - offset + 351, n/702 clamped to 0..255.
  logic signed [tttm_pkg::MILLI_W-1:0] t_ext;
  logic signed [tttm_pkg::MILLI_W-1:0] t_milli;
  logic signed [tttm_pkg::MILLI_W-1:0] n;
  logic [tttm_pkg::RECIP_W-1:0] c_prod;

  assign t_ext   = tttm_pkg::MILLI_W'(degc_in);
  assign t_milli = (t_ext <<< 10) - (t_ext <<< 4) - (t_ext <<< 3);
  assign n       = t_milli - tttm_pkg::MILLI_W'(cal_offset)
                   + tttm_pkg::MILLI_W'(tttm_pkg::HALF_SLOPE);
  assign c_prod  = tttm_pkg::RECIP_W'(n[tttm_pkg::PROD_W-1:0]) * tttm_pkg::RECIP_702;

  always_comb begin
    if (n[tttm_pkg::MILLI_W-1] || n == '0) begin
      code_out = '0;
    end else if (n >= tttm_pkg::MILLI_W'(tttm_pkg::CLAMP_LIMIT)) begin
      code_out = tttm_pkg::CODE_MAX;
    end else begin
      code_out = c_prod[tttm_pkg::RECIP_SHIFT +: tttm_pkg::CODE_W];
    end
  end

endmodule

FILE: design/tttm_trip_bank.sv
// Trip codes and enables with the neighbour order check and sample hit detection.
module tttm_trip_bank (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  tttm_pkg::bank_op_t  op,
  output tttm_pkg::bank_sts_t sts
);

  logic [tttm_pkg::CODE_W-1:0] codes [tttm_pkg::NUM_TRIPS];
  logic [tttm_pkg::NUM_TRIPS-1:0] enabled;

  logic [tttm_pkg::CODE_W-1:0] lo_bound;
  logic [tttm_pkg::CODE_W-1:0] hi_bound;
  logic [tttm_pkg::CODE_W-1:0] chk_code;
  logic                        order_ok;

  // Nearest enabled neighbour on each side; a later match overrides an earlier one.
  always_comb begin
    lo_bound = '0;
    hi_bound = tttm_pkg::CODE_MAX;
    for (int k = tttm_pkg::NUM_TRIPS - 1; k >= 0; k--) begin
      if (k > int'(op.idx) && enabled[k]) begin
        lo_bound = codes[k];
      end
    end
    for (int k = 0; k < tttm_pkg::NUM_TRIPS; k++) begin
      if (k < int'(op.idx) && enabled[k]) begin
        hi_bound = codes[k];
      end
    end
  end

  assign chk_code = (op.kind == tttm_pkg::REQ_SET_TRIP) ? op.new_code : codes[op.idx];
  assign order_ok = (chk_code >= lo_bound) && (chk_code <= hi_bound);

  always_comb begin
    sts = '0;
    sts.sel_code = codes[op.idx];
    case (op.kind)
      tttm_pkg::REQ_SAMPLE: begin
        sts.upper_hit = enabled[tttm_pkg::TRIP_UPPER]
                        && (op.sensor_code >= codes[tttm_pkg::TRIP_UPPER]);
        sts.lower_hit = enabled[tttm_pkg::TRIP_LOWER]
                        && (op.sensor_code <= codes[tttm_pkg::TRIP_LOWER]);
      end
      tttm_pkg::REQ_SET_TRIP:   sts.order_error = !order_ok;
      tttm_pkg::REQ_SET_ENABLE: sts.order_error = op.enable && !order_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < tttm_pkg::NUM_TRIPS; k++) begin
        codes[k] <= tttm_pkg::TRIP_RESET[k];
      end
      enabled <= '0;
    end else if (fire) begin
      if (op.kind == tttm_pkg::REQ_SET_TRIP && order_ok) begin
        codes[op.idx] <= op.new_code;
      end
      if (op.kind == tttm_pkg::REQ_SET_ENABLE) begin
        if (!op.enable) begin
          enabled[op.idx] <= 1'b0;
        end else if (order_ok) begin
          enabled[op.idx] <= 1'b1;
        end
      end
    end
  end

  // Enabled trips always stay in non-increasing code order by index.
  logic order_intact;
  always_comb begin
    order_intact = 1'b1;
    for (int i = 0; i < tttm_pkg::NUM_TRIPS; i++) begin
      for (int j = 0; j < tttm_pkg::NUM_TRIPS; j++) begin
        if (i < j && enabled[i] && enabled[j] && codes[i] < codes[j]) begin
          order_intact = 1'b0;
        end
      end
    end
  end

  a_trip_order: assert property (@(posedge clk) disable iff (rst) order_intact)
    else $error("enabled trip codes out of order");

endmodule

FILE: design/thermal_trip_threshold_monitor.sv
// A request accepted into the input register has its response registered as it moves on.
// Throughput: one request per cycle unless the response stalls; the input register and the
// response register each hold one transaction, so a new request is taken while a
// response waits. Each request is converted, checked and applied as it moves on.
// Reset (rst, synchronous, active high) empties both stages, restores the default trip
// codes, disables every trip and clears the calibration code to zero.
module thermal_trip_threshold_monitor (
  input  logic                             clk,
  input  logic                             rst,
  tttm_req_if.sink                         req,
  tttm_rsp_if.source                       rsp,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tttm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tttm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tttm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  logic signed [tttm_pkg::OFFSET_W-1:0] cal_offset;

  // Calibration register and derived offset.
  tttm_apb_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cal_offset (cal_offset)
  );

  // Input register. A transaction leaves it when the response register is free
  // or is being emptied in the same cycle; that move is also the moment the trip
  // state is updated, so every request sees the state its predecessors left.
  tttm_pkg::req_t s1_req;
  logic           s1_valid;
  logic           s1_move;
  logic           req_fire;
  logic           out_valid;

  assign s1_move   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_move;
  assign req_fire  = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_req.kind        <= tttm_pkg::req_kind_t'(req.req_type);
      s1_req.sensor_code <= req.sensor_code;
      s1_req.trip_index  <= req.trip_index;
      s1_req.temp_degc   <= req.temp_degc;
      s1_req.trip_enable <= req.trip_enable;
    end
  end

  // Trip bank and the shared conversion logic. A read request converts the
  // stored trip code; a sample converts the sensor code.
  tttm_pkg::bank_op_t  bank_op;
  tttm_pkg::bank_sts_t bank_sts;
  logic [tttm_pkg::CODE_W-1:0]            conv_code_in;
  logic [tttm_pkg::CODE_W-1:0]            conv_code_out;
  logic signed [tttm_pkg::DEGC_OUT_W-1:0] conv_degc;

  assign conv_code_in = (s1_req.kind == tttm_pkg::REQ_READ_TRIP) ? bank_sts.sel_code
                                                                 : s1_req.sensor_code;

  tttm_convert u_convert (
    .code_in    (conv_code_in),
    .degc_in    (s1_req.temp_degc),
    .cal_offset (cal_offset),
    .degc_out   (conv_degc),
    .code_out   (conv_code_out)
  );

  always_comb begin
    bank_op.kind        = s1_req.kind;
    bank_op.idx         = s1_req.trip_index;
    bank_op.new_code    = conv_code_out;
    bank_op.enable      = s1_req.trip_enable;
    bank_op.sensor_code = s1_req.sensor_code;
  end

  tttm_trip_bank u_bank (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_move),
    .op   (bank_op),
    .sts  (bank_sts)
  );

  // Response register. Temperature is reported only for sample and read requests.
  logic signed [tttm_pkg::DEGC_OUT_W-1:0] temp_next;

  always_comb begin
    case (s1_req.kind) inside
      tttm_pkg::REQ_SAMPLE, tttm_pkg::REQ_READ_TRIP: temp_next = conv_degc;
      default:                                        temp_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp.temp_out    <= temp_next;
      rsp.upper_hit   <= bank_sts.upper_hit;
      rsp.lower_hit   <= bank_sts.lower_hit;
      rsp.order_error <= bank_sts.order_error;
    end
  end

  assign rsp.valid = out_valid;

  // A held request keeps its contents until it moves on.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_req))
    else $error("input register lost or changed a waiting request");

  // Requests are refused only when both stages are full and the response is stalled.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> s1_valid && out_valid && !rsp.ready)
    else $error("request refused while a stage was free");

  // A rejected set or enable carries no temperature and no hits.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.order_error |->
      rsp.temp_out == '0 && !rsp.upper_hit && !rsp.lower_hit)
    else $error("order error response carries sample fields");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the thermal trip threshold monitor: directed table, then random traffic.
module tb_top;

  // Conversion constants of the sensor: 0.702 degC per code, calibrated at 30 degC,
  // all arithmetic carried in millidegrees.
  localparam int MILLI_PER_CODE = 702;
  localparam int MILLI_PER_DEG  = 1000;
  localparam int MILLI_AT_CAL   = 30000;
  localparam int CODE_TOP       = 255;

  // Trip slots that the package does not name.
  localparam logic [tttm_pkg::IDX_W-1:0] TRIP_CRIT_HIGH = 2'd0;
  localparam logic [tttm_pkg::IDX_W-1:0] TRIP_CRIT_LOW  = 2'd3;

  // The calibration code is the only register, so it sits at byte address zero.
  localparam logic [tttm_pkg::APB_ADDR_W-1:0] CAL_ADDR = {tttm_pkg::CFG_IDX_CAL, 2'b00};

  localparam int ITEMS_PER_PHASE = 305;
  localparam int NUM_PHASES      = 5;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int LONG_HOLD       = 80;

  // One response transaction as the checker sees it.
  typedef struct packed {
    logic signed [tttm_pkg::DEGC_OUT_W-1:0] temp_out;
    logic                                   upper_hit;
    logic                                   lower_hit;
    logic                                   order_error;
  } trip_result_t;

  // One row of the directed table: the request, and a hand-written expectation
  // that replaces the computed one when typed is set.
  typedef struct packed {
    tttm_pkg::req_t rq;
    logic           typed;
    trip_result_t   want;
  } directed_row_t;

  typedef enum logic [1:0] {
    RCV_ALWAYS,
    RCV_COIN,
    RCV_MOSTLY,
    RCV_EVERY_THIRD
  } rcv_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [tttm_pkg::APB_ADDR_W-1:0] paddr;
  logic [tttm_pkg::APB_DATA_W-1:0] pwdata;
  logic [tttm_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  tttm_req_if req_bus ();
  tttm_rsp_if rsp_bus ();

  thermal_trip_threshold_monitor uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_bus),
    .rsp     (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // Mirror of the block's state, advanced once per accepted request transaction.
  logic [tttm_pkg::CODE_W-1:0] trip_code [tttm_pkg::NUM_TRIPS] = '{8'hFF, 8'hDF, 8'h50, 8'h38};
  logic                        trip_on   [tttm_pkg::NUM_TRIPS] = '{1'b0, 1'b0, 1'b0, 1'b0};
  logic [tttm_pkg::CODE_W-1:0] cal_code = '0;

  trip_result_t expected_rsp [$];
  int mismatches     = 0;
  int requests_taken = 0;
  int burst_left     = 0;
  int cycle_count    = 0;

  // Directed table, run right after reset with the calibration code at zero,
  // so the offset is a plain 30000 millidegrees and most answers are easy to
  // work out by hand. It walks the extreme codes and temperatures, every
  // request type, rejected sets and enables, and an always-successful disable.
  directed_row_t directed_tab [24] = '{
    // Extreme sample codes with every trip disabled: no hits.
    '{'{tttm_pkg::REQ_SAMPLE, 8'd0, TRIP_CRIT_HIGH, 11'sd0, 1'b0},
      1'b1, '{9'sd30, 1'b0, 1'b0, 1'b0}},
    '{'{tttm_pkg::REQ_SAMPLE, 8'd255, TRIP_CRIT_HIGH, 11'sd0, 1'b0},
      1'b1, '{9'sd209, 1'b0, 1'b0, 1'b0}},
    // Reset trip codes read back as temperatures.
    '{'{tttm_pkg::REQ_READ_TRIP, 8'd0, TRIP_CRIT_HIGH, 11'sd0, 1'b0},
      1'b1, '{9'sd209, 1'b0, 1'b0, 1'b0}},
    '{'{tttm_pkg::REQ_READ_TRIP, 8'd0, tttm_pkg::TRIP_UPPER, 11'sd0, 1'b0},
      1'b1, '{9'sd187, 1'b0, 1'b0, 1'b0}},
    '{'{tttm_pkg::REQ_READ_TRIP, 8'd0, tttm_pkg::TRIP_LOWER, 11'sd0, 1'b0},
      1'b1, '{9'sd86, 1'b0, 1'b0, 1'b0}},
    '{'{tttm_pkg::REQ_READ_TRIP, 8'd0, TRIP_CRIT_LOW, 11'sd0, 1'b0},
      1'b1, '{9'sd69, 1'b0, 1'b0, 1'b0}},
    // Enable upper and lower; both fit between their neighbours.
    '{'{tttm_pkg::REQ_SET_ENABLE, 8'd0, tttm_pkg::TRIP_UPPER, 11'sd0, 1'b1},
      1'b1, '{9'sd0, 1'b0, 1'b0, 1'b0}},
    '{'{tttm_pkg::REQ_SET_ENABLE, 8'd0, tttm_pkg::TRIP_LOWER, 11'sd0, 1'b1},
      1'b1, '{9'sd0, 1'b0, 1'b0, 1'b0}},
    // Samples exactly on the upper and on the lower trip code.
    '{'{tttm_pkg::REQ_SAMPLE, 8'd223, TRIP_CRIT_HIGH, 11'sd0, 1'b0},
      1'b1, '{9'sd187, 1'b1, 1'b0, 1'b0}},
    '{'{tttm_pkg::REQ_SAMPLE, 8'd80, TRIP_CRIT_HIGH, 11'sd0, 1'b0},
      1'b1, '{9'sd86, 1'b0, 1'b1, 1'b0}},
    // Out of range temperatures clamp to the code extremes and break the order.
    '{'{tttm_pkg::REQ_SET_TRIP, 8'd0, tttm_pkg::TRIP_LOWER, 11'sd1000, 1'b0},
      1'b1, '{9'sd0, 1'b0, 1'b0, 1'b1}},
    '{'{tttm_pkg::REQ_SET_TRIP, 8'd0, tttm_pkg::TRIP_UPPER, -11'sd1000, 1'b0},
      1'b1, '{9'sd0, 1'b0, 1'b0, 1'b1}},
    // Most negative and most positive temperatures on the critical trips.
    '{'{tttm_pkg::REQ_SET_TRIP, 8'd0, TRIP_CRIT_LOW, 11'h400, 1'b0},
      1'b1, '{9'sd0, 1'b0, 1'b0, 1'b0}},
    '{'{tttm_pkg::REQ_SET_ENABLE, 8'd0, TRIP_CRIT_LOW, 11'sd0, 1'b1},
      1'b1, '{9'sd0, 1'b0, 1'b0, 1'b0}},
    '{'{tttm_pkg::REQ_SET_TRIP, 8'd0, TRIP_CRIT_HIGH, 11'sd1023, 1'b0},
      1'b1, '{9'sd0, 1'b0, 1'b0, 1'b0}},
    '{'{tttm_pkg::REQ_SET_ENABLE, 8'd0, TRIP_CRIT_HIGH, 11'sd0, 1'b1},
      1'b1, '{9'sd0, 1'b0, 1'b0, 1'b0}},
    // Disable upper, pull critical high below it, then re-enabling upper must fail.
    '{'{tttm_pkg::REQ_SET_ENABLE, 8'd0, tttm_pkg::TRIP_UPPER, 11'sd0, 1'b0},
      1'b1, '{9'sd0, 1'b0, 1'b0, 1'b0}},
    '{'{tttm_pkg::REQ_SET_TRIP, 8'd0, TRIP_CRIT_HIGH, 11'sd100, 1'b0},
      1'b0, '0},
    '{'{tttm_pkg::REQ_SET_ENABLE, 8'd0, tttm_pkg::TRIP_UPPER, 11'sd0, 1'b1},
      1'b1, '{9'sd0, 1'b0, 1'b0, 1'b1}},
    '{'{tttm_pkg::REQ_READ_TRIP, 8'd0, TRIP_CRIT_HIGH, 11'sd0, 1'b0},
      1'b0, '0},
    '{'{tttm_pkg::REQ_SAMPLE, 8'd255, tttm_pkg::TRIP_LOWER, 11'sd0, 1'b0},
      1'b0, '0},
    '{'{tttm_pkg::REQ_SET_ENABLE, 8'd0, TRIP_CRIT_LOW, 11'sd0, 1'b0},
      1'b1, '{9'sd0, 1'b0, 1'b0, 1'b0}},
    '{'{tttm_pkg::REQ_SET_TRIP, 8'd0, tttm_pkg::TRIP_LOWER, 11'sd30, 1'b0},
      1'b0, '0},
    '{'{tttm_pkg::REQ_SAMPLE, 8'd128, tttm_pkg::TRIP_UPPER, 11'sd0, 1'b0},
      1'b0, '0}
  };

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Calibrated offset in millidegrees.
  function automatic int cal_offset();
    return MILLI_AT_CAL - MILLI_PER_CODE * int'(cal_code);
  endfunction

  // Sensor code to whole degrees, rounded half away from zero.
  function automatic int code_degc(input logic [tttm_pkg::CODE_W-1:0] code);
    int milli;
    milli = int'(code) * MILLI_PER_CODE + cal_offset();
    if (milli > 0) begin
      return (milli + MILLI_PER_DEG / 2) / MILLI_PER_DEG;
    end else if (milli < 0) begin
      return -((-milli + MILLI_PER_DEG / 2) / MILLI_PER_DEG);
    end
    return 0;
  endfunction

  // Whole degrees to the nearest code, clamped to the code range.
  function automatic logic [tttm_pkg::CODE_W-1:0] degc_code(input int degc);
    int num;
    num = degc * MILLI_PER_DEG - cal_offset() + MILLI_PER_CODE / 2;
    if (num <= 0) begin
      return '0;
    end
    num = num / MILLI_PER_CODE;
    if (num > CODE_TOP) begin
      return tttm_pkg::CODE_MAX;
    end
    return num[tttm_pkg::CODE_W-1:0];
  endfunction

  // A code fits a slot when it lies between the nearest enabled trips on
  // either side; the slot's own enable does not matter.
  function automatic logic fits_between(input logic [tttm_pkg::IDX_W-1:0] idx,
                                        input logic [tttm_pkg::CODE_W-1:0] code);
    logic [tttm_pkg::CODE_W-1:0] lo;
    logic [tttm_pkg::CODE_W-1:0] hi;
    int k;
    lo = '0;
    hi = tttm_pkg::CODE_MAX;
    for (k = int'(idx) + 1; k < tttm_pkg::NUM_TRIPS; k++) begin
      if (trip_on[k]) begin
        lo = trip_code[k];
        break;
      end
    end
    for (k = int'(idx) - 1; k >= 0; k--) begin
      if (trip_on[k]) begin
        hi = trip_code[k];
        break;
      end
    end
    return (code >= lo) && (code <= hi);
  endfunction

  // Applies one request to the mirrored trip bank and returns its response.
  function automatic trip_result_t trip_bank_step(input tttm_pkg::req_t r);
    trip_result_t res;
    logic [tttm_pkg::CODE_W-1:0] code;
    int degc;
    res = '0;
    case (r.kind)
      tttm_pkg::REQ_SAMPLE: begin
        degc = code_degc(r.sensor_code);
        res.temp_out  = degc[tttm_pkg::DEGC_OUT_W-1:0];
        res.upper_hit = trip_on[tttm_pkg::TRIP_UPPER]
                        && (r.sensor_code >= trip_code[tttm_pkg::TRIP_UPPER]);
        res.lower_hit = trip_on[tttm_pkg::TRIP_LOWER]
                        && (r.sensor_code <= trip_code[tttm_pkg::TRIP_LOWER]);
      end
      tttm_pkg::REQ_SET_TRIP: begin
        degc = $signed(r.temp_degc);
        code = degc_code(degc);
        if (fits_between(r.trip_index, code)) begin
          trip_code[r.trip_index] = code;
        end else begin
          res.order_error = 1'b1;
        end
      end
      tttm_pkg::REQ_SET_ENABLE: begin
        // Disabling never fails; enabling rechecks the stored code.
        if (!r.trip_enable) begin
          trip_on[r.trip_index] = 1'b0;
        end else if (fits_between(r.trip_index, trip_code[r.trip_index])) begin
          trip_on[r.trip_index] = 1'b1;
        end else begin
          res.order_error = 1'b1;
        end
      end
      tttm_pkg::REQ_READ_TRIP: begin
        degc = code_degc(trip_code[r.trip_index]);
        res.temp_out = degc[tttm_pkg::DEGC_OUT_W-1:0];
      end
    endcase
    return res;
  endfunction

  // Random request. Samples dominate; temperatures mostly land inside the
  // convertible range so that sets really move the trips around, and a quarter
  // of them span the whole 11-bit field to hit clamping.
  function automatic tttm_pkg::req_t random_request();
    tttm_pkg::req_t r;
    int pick;
    int degc;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.kind = tttm_pkg::REQ_SAMPLE;
    end else if (pick < 65) begin
      r.kind = tttm_pkg::REQ_SET_TRIP;
    end else if (pick < 85) begin
      r.kind = tttm_pkg::REQ_SET_ENABLE;
    end else begin
      r.kind = tttm_pkg::REQ_READ_TRIP;
    end
    r.sensor_code = tttm_pkg::CODE_W'($urandom_range(0, 255));
    r.trip_index  = tttm_pkg::IDX_W'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) begin
      degc = int'($urandom_range(0, 2047)) - 1024;
    end else begin
      degc = int'($urandom_range(0, 375)) - 160;
    end
    r.temp_degc = degc[tttm_pkg::DEGC_IN_W-1:0];
    if (r.kind == tttm_pkg::REQ_SET_ENABLE) begin
      r.trip_enable = ($urandom_range(0, 99) < 65);
    end else begin
      r.trip_enable = 1'($urandom_range(0, 1));
    end
    return r;
  endfunction

  // One APB transaction on the calibration register. Called at a rising edge,
  // returns at the edge that completes the access phase. A read is compared
  // against the mirrored register value.
  task automatic cfg_access(input logic wr, input logic [tttm_pkg::CODE_W-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CAL_ADDR;
    pwdata  <= tttm_pkg::APB_DATA_W'(wdata);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      cal_code = wdata;
    end else if (prdata !== tttm_pkg::APB_DATA_W'(cal_code)) begin
      report_mismatch($sformatf("calibration readback got %0h want %0h", prdata, cal_code));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offers one request and waits for its transaction. The sender runs in
  // bursts; between bursts valid drops for a random gap. A gap of zero keeps
  // valid high, so there is never a drop and a raise in the same time step.
  // The expectation is computed at the accepting edge, in acceptance order.
  task automatic send_request(input tttm_pkg::req_t r, input logic typed,
                              input trip_result_t want);
    int gap;
    trip_result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 10);
    end
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= r.kind;
    req_bus.sensor_code <= r.sensor_code;
    req_bus.trip_index  <= r.trip_index;
    req_bus.temp_degc   <= r.temp_degc;
    req_bus.trip_enable <= r.trip_enable;
    do @(posedge clk); while (!req_bus.ready);
    burst_left--;
    predicted = trip_bank_step(r);
    expected_rsp.push_back(typed ? want : predicted);
    requests_taken++;
  endtask

  // Stops offering and waits until every response has come back, so that the
  // block is idle before the calibration register changes. An empty queue
  // means every response transaction has been taken; the task then idles before the
  // next register access.
  task automatic drain_pending();
    req_bus.valid <= 1'b0;
    burst_left = 0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Stimulus: directed table at reset calibration, then random phases at
  // several calibration codes, including both extremes.
  initial begin
    logic [tttm_pkg::CODE_W-1:0] cal_plan [NUM_PHASES];
    cal_plan = '{8'hFF, 8'h00, 8'h80, 8'h00, 8'h00};
    cal_plan[3] = tttm_pkg::CODE_W'($urandom_range(1, 254));
    cal_plan[4] = tttm_pkg::CODE_W'($urandom_range(1, 254));

    rst                 <= 1'b1;
    req_bus.valid       <= 1'b0;
    req_bus.req_type    <= tttm_pkg::REQ_SAMPLE;
    req_bus.sensor_code <= '0;
    req_bus.trip_index  <= '0;
    req_bus.temp_degc   <= '0;
    req_bus.trip_enable <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // The register should come out of reset at zero.
    cfg_access(1'b0, '0);
    foreach (directed_tab[i]) begin
      send_request(directed_tab[i].rq, directed_tab[i].typed, directed_tab[i].want);
    end
    drain_pending();

    for (int p = 0; p < NUM_PHASES; p++) begin
      cfg_access(1'b1, cal_plan[p]);
      cfg_access(1'b0, '0);
      repeat (ITEMS_PER_PHASE) send_request(random_request(), 1'b0, '0);
      drain_pending();
    end

    // Let any stray response show up before the verdict.
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver. Ready follows one of four patterns, picked at random at each change: always
  // ready, coin flips, mostly ready, or ready two thirds of the time. Once, after a few
  // hundred requests, it holds off for a long stretch while the sender keeps
  // offering, so both pipeline registers fill and the request side stalls.
  // Shorter hold-offs also turn up at random pattern changes.
  initial begin
    int hold_left;
    int rcv_cycle;
    logic long_hold_done;
    rcv_mode_t rcv_mode;
    hold_left      = 0;
    rcv_cycle      = 0;
    long_hold_done = 1'b0;
    rcv_mode       = RCV_ALWAYS;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rcv_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (!long_hold_done && requests_taken >= 300) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        rsp_bus.ready <= 1'b0;
      end else begin
        if (rcv_cycle % 64 == 0) begin
          rcv_mode = rcv_mode_t'($urandom_range(0, 3));
          if ($urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(20, 50);
          end
        end
        case (rcv_mode)
          RCV_ALWAYS:      rsp_bus.ready <= 1'b1;
          RCV_COIN:        rsp_bus.ready <= 1'($urandom_range(0, 1));
          RCV_MOSTLY:      rsp_bus.ready <= ($urandom_range(0, 9) != 0);
          RCV_EVERY_THIRD: rsp_bus.ready <= (rcv_cycle % 3 != 0);
        endcase
      end
    end
  end

  // Response checker. Values are read right after the edge, so they are the
  // ones the block presented during the accepting cycle.
  always @(posedge clk) begin
    trip_result_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("response transaction with no request pending");
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_bus.temp_out !== want.temp_out) begin
          report_mismatch($sformatf("temp_out got %0d want %0d",
                                    rsp_bus.temp_out, want.temp_out));
        end
        if (rsp_bus.upper_hit !== want.upper_hit) begin
          report_mismatch($sformatf("upper_hit got %b want %b",
                                    rsp_bus.upper_hit, want.upper_hit));
        end
        if (rsp_bus.lower_hit !== want.lower_hit) begin
          report_mismatch($sformatf("lower_hit got %b want %b",
                                    rsp_bus.lower_hit, want.lower_hit));
        end
        if (rsp_bus.order_error !== want.order_error) begin
          report_mismatch($sformatf("order_error got %b want %b",
                                    rsp_bus.order_error, want.order_error));
        end
      end
    end
  end

  // Watchdog: the slowest legal run stays far below this.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
